[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk_i edge, off while rst_ni is low
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_CLK(lbl, !(cond), msg)

`endif

[rtl/core/ufhf_pkg.sv]
// Package for the UDP flow header filter: constants and register map
`timescale 1ns / 1ps

package ufhf_pkg;

  localparam int unsigned IDX_W = 15;
  localparam int unsigned OFS_W = 7;

  localparam logic [IDX_W-1:0] INDEX_MAX       = 15'h7fff;
  localparam logic [IDX_W-1:0] POS_ETYPE_HI    = 15'd12;
  localparam logic [IDX_W-1:0] POS_ETYPE_LO    = 15'd13;
  localparam logic [IDX_W-1:0] POS_IHL         = 15'd14;
  localparam logic [IDX_W-1:0] POS_PROTO       = 15'd23;
  localparam logic [IDX_W-1:0] POS_SRC_FIRST   = 15'd26;
  localparam logic [IDX_W-1:0] POS_SRC_LAST    = 15'd29;
  localparam logic [IDX_W-1:0] POS_DST_FIRST   = 15'd30;
  localparam logic [IDX_W-1:0] POS_DST_LAST    = 15'd33;
  localparam logic [IDX_W-1:0] POS_MIN_LAST    = 15'd41;   // 42-byte minimum frame

  localparam logic [OFS_W-1:0] ETH_HDR_BYTES   = 7'd14;
  localparam logic [OFS_W-1:0] UDP_HDR_BYTES   = 7'd8;
  localparam logic [7:0]       ETYPE_IPV4_HI   = 8'h08;
  localparam logic [7:0]       ETYPE_IPV4_LO   = 8'h00;
  localparam logic [7:0]       PROTO_UDP       = 8'd17;
  localparam logic [3:0]       IHL_MASK        = 4'hf;

  typedef enum logic [1:0] {
    REG_MATCH_PORT   = 2'd0,
    REG_GROUP_ADDR   = 2'd1,
    REG_SOURCE_ADDR  = 2'd2,
    REG_STAMP_ENABLE = 2'd3
  } cfg_reg_e;

endpackage

[rtl/core/ufhf_in_if.sv]
// Stream interface carrying frame bytes into the filter
`timescale 1ns / 1ps

interface ufhf_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  frame_byte;
  logic        frame_end;
  logic        stamp_valid;
  logic [63:0] stamp_ns;

  modport source (output valid, frame_byte, frame_end, stamp_valid, stamp_ns, input ready);
  modport sink   (input valid, frame_byte, frame_end, stamp_valid, stamp_ns, output ready);
endinterface

[rtl/core/ufhf_out_if.sv]
// Stream interface carrying per-frame verdicts out of the filter
`timescale 1ns / 1ps

interface ufhf_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [6:0]  payload_offset;
  logic [15:0] payload_length;
  logic        has_stamp;
  logic [63:0] stamp_out;

  modport source (output valid, accepted, payload_offset, payload_length, has_stamp,
                  stamp_out, input ready);
  modport sink   (input valid, accepted, payload_offset, payload_length, has_stamp,
                  stamp_out, output ready);
endinterface

[rtl/core/udp_flow_header_filter_top.sv]
// The verdict is valid in the cycle after the transaction that carries frame end.
// Header state updates in the same cycle a byte is taken.
// 1 byte per cycle is taken while the verdict register is empty or being read.
// Reset (rst_ni low, async): config and valid cleared, frame state to start-of-frame.
// Frame state returns to start-of-frame after every frame end.
`timescale 1ns / 1ps

module udp_flow_header_filter_top
  import ufhf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  ufhf_in_if.sink           frame_i,
  ufhf_out_if.source        verdict_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // configuration
  logic [15:0] match_port_q;
  logic [31:0] group_addr_q;
  logic [31:0] source_addr_q;
  logic        stamp_enable_q;
  cfg_reg_e    reg_sel;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_e'(paddr[3:2]);
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_port_q   <= '0;
      group_addr_q   <= '0;
      source_addr_q  <= '0;
      stamp_enable_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_MATCH_PORT:   match_port_q   <= pwdata[15:0];
        REG_GROUP_ADDR:   group_addr_q   <= pwdata;
        REG_SOURCE_ADDR:  source_addr_q  <= pwdata;
        REG_STAMP_ENABLE: stamp_enable_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_MATCH_PORT:   prdata = {16'd0, match_port_q};
      REG_GROUP_ADDR:   prdata = group_addr_q;
      REG_SOURCE_ADDR:  prdata = source_addr_q;
      REG_STAMP_ENABLE: prdata = {31'd0, stamp_enable_q};
      default:          prdata = '0;
    endcase
  end

  // frame state
  logic [IDX_W-1:0] byte_index_q, byte_index_d;
  logic [OFS_W-1:0] udp_start_q, udp_start_d;
  logic             headers_ok_q, headers_ok_d;
  logic [31:0]      src_addr_q, src_addr_d;
  logic [31:0]      dst_addr_q, dst_addr_d;
  logic [15:0]      dst_port_q, dst_port_d;
  logic [15:0]      udp_len_q, udp_len_d;

  logic             in_xfer;
  logic [7:0]       b;
  logic [IDX_W-1:0] pos;
  logic [IDX_W-1:0] udp_base;
  logic             frame_ok;
  logic             stamp_sel;

  assign in_xfer       = frame_i.valid & frame_i.ready;
  assign frame_i.ready = ~verdict_o.valid | verdict_o.ready;
  assign b             = frame_i.frame_byte;
  assign pos           = byte_index_q;
  assign udp_base      = {{(IDX_W-OFS_W){1'b0}}, udp_start_q};

  always_comb begin
    headers_ok_d = headers_ok_q;
    udp_start_d  = udp_start_q;
    src_addr_d   = src_addr_q;
    dst_addr_d   = dst_addr_q;
    dst_port_d   = dst_port_q;
    udp_len_d    = udp_len_q;

    if (pos == POS_ETYPE_HI && b != ETYPE_IPV4_HI) headers_ok_d = 1'b0;
    if (pos == POS_ETYPE_LO && b != ETYPE_IPV4_LO) headers_ok_d = 1'b0;
    if (pos == POS_PROTO    && b != PROTO_UDP)     headers_ok_d = 1'b0;
    if (pos == POS_IHL)
      udp_start_d = ETH_HDR_BYTES + {1'b0, b[3:0] & IHL_MASK, 2'b00};
    if (pos >= POS_SRC_FIRST && pos <= POS_SRC_LAST) src_addr_d = {src_addr_q[23:0], b};
    if (pos >= POS_DST_FIRST && pos <= POS_DST_LAST) dst_addr_d = {dst_addr_q[23:0], b};
    // udp_start is settled by now; with a small IHL the fields may overlap the IP header
    if (pos > POS_IHL) begin
      if (pos == udp_base + 15'd2 || pos == udp_base + 15'd3)
        dst_port_d = {dst_port_q[7:0], b};
      if (pos == udp_base + 15'd4 || pos == udp_base + 15'd5)
        udp_len_d = {udp_len_q[7:0], b};
    end

    byte_index_d = (pos < INDEX_MAX) ? pos + 15'd1 : pos;

    frame_ok = headers_ok_d
             && pos >= POS_MIN_LAST
             && pos >= {{(IDX_W-OFS_W){1'b0}}, udp_start_d} + 15'd7
             && dst_port_d == match_port_q
             && (group_addr_q == '0 || dst_addr_d == group_addr_q)
             && (source_addr_q == '0 || src_addr_d == source_addr_q)
             && udp_len_d >= {9'd0, UDP_HDR_BYTES};
    stamp_sel = frame_ok & stamp_enable_q & frame_i.stamp_valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q <= '0;
      udp_start_q  <= '0;
      headers_ok_q <= 1'b1;
      src_addr_q   <= '0;
      dst_addr_q   <= '0;
      dst_port_q   <= '0;
      udp_len_q    <= '0;
    end else if (in_xfer) begin
      if (frame_i.frame_end) begin
        byte_index_q <= '0;
        udp_start_q  <= '0;
        headers_ok_q <= 1'b1;
        src_addr_q   <= '0;
        dst_addr_q   <= '0;
        dst_port_q   <= '0;
        udp_len_q    <= '0;
      end else begin
        byte_index_q <= byte_index_d;
        udp_start_q  <= udp_start_d;
        headers_ok_q <= headers_ok_d;
        src_addr_q   <= src_addr_d;
        dst_addr_q   <= dst_addr_d;
        dst_port_q   <= dst_port_d;
        udp_len_q    <= udp_len_d;
      end
    end
  end

  // verdict register
  logic        res_valid_q;
  logic        res_acc_q;
  logic [6:0]  res_ofs_q;
  logic [15:0] res_len_q;
  logic        res_has_q;
  logic [63:0] res_stamp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (in_xfer && frame_i.frame_end) begin
      res_valid_q <= 1'b1;
    end else if (verdict_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && frame_i.frame_end) begin
      res_acc_q   <= frame_ok;
      res_ofs_q   <= frame_ok ? udp_start_d + UDP_HDR_BYTES : '0;
      res_len_q   <= frame_ok ? udp_len_d - {9'd0, UDP_HDR_BYTES} : '0;
      res_has_q   <= stamp_sel;
      res_stamp_q <= stamp_sel ? frame_i.stamp_ns : '0;
    end
  end

  assign verdict_o.valid          = res_valid_q;
  assign verdict_o.accepted       = res_acc_q;
  assign verdict_o.payload_offset = res_ofs_q;
  assign verdict_o.payload_length = res_len_q;
  assign verdict_o.has_stamp      = res_has_q;
  assign verdict_o.stamp_out      = res_stamp_q;

endmodule

[rtl/core/ufhf_checker.sv]
// Port-level checker for the UDP flow header filter, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ufhf_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        in_end_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        accepted_i,
  input  logic [6:0]  payload_offset_i,
  input  logic [15:0] payload_length_i,
  input  logic        has_stamp_i,
  input  logic [63:0] stamp_out_i
);

  // a verdict only follows a frame-end transaction
  `ASSERT_CLK(a_verdict_from_end, $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i && in_end_i), "verdict without frame end")

  // a held verdict stays until it is taken
  `ASSERT_CLK(a_verdict_hold, out_valid_i && !out_ready_i |=> out_valid_i, "verdict dropped while stalled")

  // rejected frames report zeros
  `ASSERT_NEVER(a_reject_zero, out_valid_i && !accepted_i && (payload_offset_i != 7'd0 || payload_length_i != 16'd0 || has_stamp_i), "rejected verdict carries data")

  // payload offset is 14 + 4*IHL + 8
  `ASSERT_NEVER(a_offset_form, out_valid_i && accepted_i && (payload_offset_i < 7'd22 || payload_offset_i[1:0] != 2'b10), "bad payload offset")

  `ASSERT_NEVER(a_stamp_zero, out_valid_i && !has_stamp_i && stamp_out_i != 64'd0, "stamp without has_stamp")

endmodule

bind udp_flow_header_filter_top ufhf_checker u_ufhf_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (frame_i.valid),
  .in_ready_i       (frame_i.ready),
  .in_end_i         (frame_i.frame_end),
  .out_valid_i      (verdict_o.valid),
  .out_ready_i      (verdict_o.ready),
  .accepted_i       (verdict_o.accepted),
  .payload_offset_i (verdict_o.payload_offset),
  .payload_length_i (verdict_o.payload_length),
  .has_stamp_i      (verdict_o.has_stamp),
  .stamp_out_i      (verdict_o.stamp_out)
);

[tb/udp_flow_header_filter_top_tb.sv]
// Testbench for the UDP flow header filter: directed frame table, then random frames
`timescale 1ns / 1ps

module udp_flow_header_filter_top_tb;
  import ufhf_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 4;

  typedef struct packed {
    logic        accepted;
    logic [6:0]  payload_offset;
    logic [15:0] payload_length;
    logic        has_stamp;
    logic [63:0] stamp_out;
  } verdict_t;

  localparam verdict_t REJECT = '0;

  typedef struct {
    logic [15:0] port;
    logic [31:0] group;
    logic [31:0] source;
    logic        stamp;
  } cfg_set_t;

  // One frame of stimulus; exp is used only where typed is set
  typedef struct {
    int          cfg;
    int unsigned len;
    logic [7:0]  ver_ihl;
    logic [15:0] etype;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] dport;
    logic [15:0] ulen;
    logic        sv;
    logic [63:0] stamp;
    bit          typed;
    verdict_t    exp;
  } frame_row_t;

  typedef struct {
    bit       typed;
    verdict_t v;
  } frame_plan_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ufhf_in_if  frame_if ();
  ufhf_out_if verdict_if ();

  udp_flow_header_filter_top dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .frame_i   (frame_if),
    .verdict_o (verdict_if),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // register mirror
  logic [15:0] cfg_port   = '0;
  logic [31:0] cfg_group  = '0;
  logic [31:0] cfg_source = '0;
  logic        cfg_stamp  = 1'b0;

  // per-frame header state
  logic [14:0] hdr_idx   = '0;
  logic [6:0]  hdr_udp   = '0;
  bit          hdr_ok    = 1'b1;
  logic [31:0] hdr_src   = '0;
  logic [31:0] hdr_dst   = '0;
  logic [15:0] hdr_dport = '0;
  logic [15:0] hdr_ulen  = '0;

  verdict_t    verdict_q [$];
  frame_plan_t frame_plan_q [$];
  frame_row_t  dir_rows [$];
  cfg_set_t    cfg_sets [6];

  int err_cnt     = 0;
  int idle_cycles = 0;
  int idle_pct    = 0;
  int stall_pct   = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  function automatic void add_row(input frame_row_t row);
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  // Advances the header state by one byte; returns 1 with the verdict at frame end
  function automatic bit filter_byte(input logic [7:0] b, input logic last, input logic sv,
                                     input logic [63:0] sns, output verdict_t v);
    int unsigned pos;
    bit          pass;
    pos = hdr_idx;
    v   = REJECT;
    if (pos == POS_ETYPE_HI && b != ETYPE_IPV4_HI) hdr_ok = 1'b0;
    if (pos == POS_ETYPE_LO && b != ETYPE_IPV4_LO) hdr_ok = 1'b0;
    if (pos == POS_IHL) hdr_udp = ETH_HDR_BYTES + {1'b0, b[3:0] & IHL_MASK, 2'b00};
    if (pos == POS_PROTO && b != PROTO_UDP) hdr_ok = 1'b0;
    if (pos >= POS_SRC_FIRST && pos <= POS_SRC_LAST) hdr_src = {hdr_src[23:0], b};
    if (pos >= POS_DST_FIRST && pos <= POS_DST_LAST) hdr_dst = {hdr_dst[23:0], b};
    if (pos > POS_IHL) begin
      if (pos == hdr_udp + 2 || pos == hdr_udp + 3) hdr_dport = {hdr_dport[7:0], b};
      if (pos == hdr_udp + 4 || pos == hdr_udp + 5) hdr_ulen = {hdr_ulen[7:0], b};
    end
    if (hdr_idx != INDEX_MAX) hdr_idx = hdr_idx + 1'b1;
    if (!last) return 1'b0;

    pass = hdr_ok && pos >= POS_MIN_LAST && pos + 1 >= hdr_udp + UDP_HDR_BYTES
        && hdr_dport == cfg_port
        && (cfg_group == 0 || hdr_dst == cfg_group)
        && (cfg_source == 0 || hdr_src == cfg_source)
        && hdr_ulen >= UDP_HDR_BYTES;
    if (pass) begin
      v.accepted       = 1'b1;
      v.payload_offset = hdr_udp + UDP_HDR_BYTES;
      v.payload_length = hdr_ulen - UDP_HDR_BYTES;
      v.has_stamp      = cfg_stamp && sv;
      v.stamp_out      = v.has_stamp ? sns : 64'd0;
    end
    hdr_idx   = '0;
    hdr_udp   = '0;
    hdr_ok    = 1'b1;
    hdr_src   = '0;
    hdr_dst   = '0;
    hdr_dport = '0;
    hdr_ulen  = '0;
    return 1'b1;
  endfunction

  // output side: random backpressure
  always @(posedge clk_i) begin
    verdict_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin : monitor
    verdict_t    pred;
    verdict_t    want;
    frame_plan_t plan;
    if (rst_ni) begin
      idle_cycles++;
      if (psel) idle_cycles = 0;
      if (verdict_if.valid && verdict_if.ready) begin
        idle_cycles = 0;
        if (verdict_q.size() == 0) begin
          report_mismatch("verdict with no frame end pending");
        end else begin
          want = verdict_q.pop_front();
          if (verdict_if.accepted !== want.accepted)
            report_mismatch($sformatf("accepted %b, want %b",
                                      verdict_if.accepted, want.accepted));
          if (verdict_if.payload_offset !== want.payload_offset)
            report_mismatch($sformatf("payload_offset %0d, want %0d",
                                      verdict_if.payload_offset, want.payload_offset));
          if (verdict_if.payload_length !== want.payload_length)
            report_mismatch($sformatf("payload_length %0d, want %0d",
                                      verdict_if.payload_length, want.payload_length));
          if (verdict_if.has_stamp !== want.has_stamp)
            report_mismatch($sformatf("has_stamp %b, want %b",
                                      verdict_if.has_stamp, want.has_stamp));
          if (verdict_if.stamp_out !== want.stamp_out)
            report_mismatch($sformatf("stamp_out %h, want %h",
                                      verdict_if.stamp_out, want.stamp_out));
        end
      end
      if (frame_if.valid && frame_if.ready) begin
        idle_cycles = 0;
        if (filter_byte(frame_if.frame_byte, frame_if.frame_end, frame_if.stamp_valid,
                        frame_if.stamp_ns, pred)) begin
          plan = frame_plan_q.pop_front();
          verdict_q.insert(verdict_q.size(), plan.typed ? plan.v : pred);
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // stop sending and let every pending verdict drain
  task automatic settle();
    frame_if.valid <= 1'b0;
    @(posedge clk_i);
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_access(input bit wr, input cfg_reg_e r, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {r, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_config(input cfg_set_t c);
    logic [31:0] vals [4];
    logic [31:0] rd;
    cfg_reg_e    r;
    settle();
    vals[REG_MATCH_PORT]   = {16'd0, c.port};
    vals[REG_GROUP_ADDR]   = c.group;
    vals[REG_SOURCE_ADDR]  = c.source;
    vals[REG_STAMP_ENABLE] = {31'd0, c.stamp};
    r = REG_MATCH_PORT;
    repeat (4) begin
      apb_access(1'b1, r, vals[r], rd);
      r = r.next();
    end
    r = REG_MATCH_PORT;
    repeat (4) begin
      apb_access(1'b0, r, 32'd0, rd);
      if (rd !== vals[r])
        report_mismatch($sformatf("%s reads %h, want %h", r.name(), rd, vals[r]));
      r = r.next();
    end
    cfg_port   = c.port;
    cfg_group  = c.group;
    cfg_source = c.source;
    cfg_stamp  = c.stamp;
  endtask

  // Builds the frame bytes from the row and streams them with random source gaps
  task automatic send_frame(input frame_row_t r);
    logic [7:0]  fb [];
    int unsigned us;
    int          k;
    bit          last;
    frame_plan_t plan;
    fb = new[r.len];
    foreach (fb[i]) fb[i] = 8'($urandom);
    us = 14 + 4 * r.ver_ihl[3:0];
    for (k = 0; k < 4; k++) begin
      if (26 + k < r.len) fb[26 + k] = r.src[31 - 8 * k -: 8];
      if (30 + k < r.len) fb[30 + k] = r.dst[31 - 8 * k -: 8];
    end
    for (k = 0; k < 2; k++) begin
      if (12 + k < r.len) fb[12 + k] = r.etype[15 - 8 * k -: 8];
    end
    if (23 < r.len) fb[23] = r.proto;
    // UDP fields may overlap the IP header when IHL is small
    for (k = 0; k < 2; k++) begin
      if (us + 2 + k < r.len) fb[us + 2 + k] = r.dport[15 - 8 * k -: 8];
      if (us + 4 + k < r.len) fb[us + 4 + k] = r.ulen[15 - 8 * k -: 8];
    end
    if (14 < r.len) fb[14] = r.ver_ihl;
    plan = '{r.typed, r.exp};
    frame_plan_q.insert(frame_plan_q.size(), plan);
    for (int unsigned i = 0; i < r.len; i++) begin
      while ($urandom_range(99) < idle_pct) begin
        frame_if.valid <= 1'b0;
        @(posedge clk_i);
      end
      last = (i == r.len - 1);
      frame_if.valid       <= 1'b1;
      frame_if.frame_byte  <= fb[i];
      frame_if.frame_end   <= last;
      frame_if.stamp_valid <= last ? r.sv : 1'($urandom);
      frame_if.stamp_ns    <= last ? r.stamp : {$urandom, $urandom};
      @(posedge clk_i);
      while (!frame_if.ready) @(posedge clk_i);
    end
  endtask

  initial begin
    frame_row_t  r;
    int          cur_cfg;
    int unsigned us;
    int unsigned base;
    int unsigned nbytes;
    int unsigned nframes;
    int          cat;
    int          phase_idle [4];
    int          phase_stall [4];

    rst_ni                 = 1'b0;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    frame_if.valid         = 1'b0;
    frame_if.frame_byte    = '0;
    frame_if.frame_end     = 1'b0;
    frame_if.stamp_valid   = 1'b0;
    frame_if.stamp_ns      = '0;

    cfg_sets[0] = '{16'd0, 32'd0, 32'd0, 1'b0};
    cfg_sets[1] = '{16'hffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1};
    cfg_sets[2] = '{16'd5004, 32'hef01_0203, 32'h0a00_0001, 1'b1};
    cfg_sets[3] = '{16'd319, 32'd0, 32'hc0a8_0001, 1'b0};
    cfg_sets[4] = '{16'($urandom), 32'd0, 32'd0, 1'b1};
    cfg_sets[5] = '{16'd0, 32'd0, 32'd0, 1'b0};
    phase_idle  = '{0, 54, 0, 24};
    phase_stall = '{0, 0, 54, 24};

    // cfg, len, ver_ihl, etype, proto, src, dst, dport, ulen, sv, stamp, typed, verdict
    add_row('{0, 42, 8'h00, 16'h0000, 8'd0, 32'h0, 32'h0, 16'd0, 16'd8,
              1'b1, 64'd1, 1'b1, REJECT});
    add_row('{0, 42, 8'h45, 16'h0800, 8'd17, 32'h0, 32'h0, 16'd0, 16'd8,
              1'b1, 64'd5, 1'b1, '{1'b1, 7'd42, 16'd0, 1'b0, 64'd0}});
    add_row('{0, 42, 8'h45, 16'h0800, 8'd17, 32'h0, 32'h0, 16'd0, 16'd7,
              1'b1, 64'd5, 1'b1, REJECT});
    add_row('{0, 41, 8'h45, 16'h0800, 8'd17, 32'h0, 32'h0, 16'd0, 16'd8,
              1'b1, 64'd5, 1'b1, REJECT});
    add_row('{0, 50, 8'h45, 16'h0800, 8'd6, 32'h0, 32'h0, 16'd0, 16'd8,
              1'b1, 64'd5, 1'b1, REJECT});
    add_row('{0, 50, 8'h45, 16'h86dd, 8'd17, 32'h0, 32'h0, 16'd0, 16'd8,
              1'b1, 64'd5, 1'b1, REJECT});
    add_row('{0, 60, 8'h45, 16'h0800, 8'd17, 32'h0a00_0001, 32'hef00_0001,
              16'd0, 16'hffff, 1'b1, 64'd7, 1'b1,
              '{1'b1, 7'd42, 16'd65527, 1'b0, 64'd0}});
    add_row('{1, 42, 8'h45, 16'h0800, 8'd17, 32'hffff_ffff, 32'hffff_ffff,
              16'hffff, 16'd8, 1'b1, '1, 1'b1,
              '{1'b1, 7'd42, 16'd0, 1'b1, 64'hffff_ffff_ffff_ffff}});
    add_row('{1, 42, 8'h45, 16'h0800, 8'd17, 32'hffff_ffff, 32'hffff_ffff,
              16'hffff, 16'd8, 1'b0, '1, 1'b1, '{1'b1, 7'd42, 16'd0, 1'b0, 64'd0}});
    add_row('{1, 42, 8'h45, 16'h0800, 8'd17, 32'hffff_ffff, 32'hffff_fffe,
              16'hffff, 16'd8, 1'b1, '1, 1'b1, REJECT});
    add_row('{1, 42, 8'h45, 16'h0800, 8'd17, 32'h0, 32'hffff_ffff,
              16'hffff, 16'd8, 1'b1, '1, 1'b1, REJECT});
    add_row('{1, 82, 8'h4f, 16'h0800, 8'd17, 32'hffff_ffff, 32'hffff_ffff,
              16'hffff, 16'd100, 1'b1, 64'h0123_4567_89ab_cdef, 1'b1,
              '{1'b1, 7'd82, 16'd92, 1'b1, 64'h0123_4567_89ab_cdef}});
    add_row('{1, 81, 8'h4f, 16'h0800, 8'd17, 32'hffff_ffff, 32'hffff_ffff,
              16'hffff, 16'd100, 1'b1, 64'd3, 1'b1, REJECT});
    // IHL below five: UDP header overlaps the IP header
    add_row('{1, 50, 8'h40, 16'h0800, 8'd17, 32'hffff_ffff, 32'hffff_ffff,
              16'hffff, 16'h0100, 1'b1, 64'd9, 1'b0, REJECT});
    add_row('{1, 50, 8'h42, 16'h0800, 8'd17, 32'hffff_ffff, 32'hffff_ffff,
              16'hffff, 16'h0100, 1'b1, 64'd9, 1'b0, REJECT});
    add_row('{1, 60, 8'h43, 16'h0800, 8'd17, 32'hffff_ffff, 32'hffff_ffff,
              16'hffff, 16'hffff, 1'b1, 64'd9, 1'b0, REJECT});
    add_row('{3, 64, 8'h45, 16'h0800, 8'd17, 32'hc0a8_0001, 32'hdead_beef,
              16'd319, 16'd64, 1'b1, 64'd11, 1'b0, REJECT});
    add_row('{3, 90, 8'hff, 16'h0800, 8'd17, 32'hc0a8_0001, 32'h0,
              16'd319, 16'd20, 1'b1, 64'd12, 1'b0, REJECT});
    add_row('{3, 1, 8'h45, 16'h0800, 8'd17, 32'h0, 32'h0, 16'd0, 16'd0,
              1'b1, 64'd13, 1'b1, REJECT});
    add_row('{3, 42, 8'h47, 16'h0800, 8'd17, 32'hc0a8_0001, 32'h0,
              16'd319, 16'd8, 1'b1, 64'd14, 1'b0, REJECT});
    add_row('{3, 42, 8'h45, 16'h0800, 8'd17, 32'hc0a8_0001, 32'h1,
              16'd319, 16'd8, 1'b1, 64'd0, 1'b1, '{1'b1, 7'd42, 16'd0, 1'b0, 64'd0}});

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    cur_cfg = 0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg != cur_cfg) begin
        load_config(cfg_sets[dir_rows[i].cfg]);
        cur_cfg = dir_rows[i].cfg;
      end
      send_frame(dir_rows[i]);
    end

    for (int p = 0; p < 4; p++) begin
      load_config(cfg_sets[2 + p]);
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      nbytes    = 0;
      nframes   = 0;
      while (nbytes < 64 || nframes < 2) begin
        cat       = $urandom_range(99);
        r.cfg     = 2 + p;
        r.typed   = 1'b0;
        r.exp     = REJECT;
        r.ver_ihl = ($urandom_range(9) == 0) ? 8'($urandom) :
                    {4'h4, ($urandom_range(7) == 0) ? 4'($urandom) : 4'h5};
        r.etype   = 16'h0800;
        r.proto   = PROTO_UDP;
        r.src     = (cfg_source != 0 && $urandom_range(9) != 0) ? cfg_source : $urandom;
        r.dst     = (cfg_group != 0 && $urandom_range(9) != 0) ? cfg_group : $urandom;
        r.dport   = ($urandom_range(9) != 0) ? cfg_port : 16'($urandom);
        r.ulen    = ($urandom_range(7) == 0) ? 16'($urandom_range(15)) :
                    16'($urandom_range(1500, 8));
        r.sv      = 1'($urandom);
        r.stamp   = {$urandom, $urandom};
        us        = 14 + 4 * r.ver_ihl[3:0];
        base      = (us + 8 > 42) ? us + 8 : 42;
        r.len     = base + $urandom_range(24);
        if ($urandom_range(9) == 0) r.len = $urandom_range(base - 1, 1);
        if ($urandom_range(49) == 0) r.len = r.len + $urandom_range(600, 100);
        if (cat >= 70 && cat < 85) begin
          // broken header
          if ($urandom_range(1)) r.etype = 16'($urandom);
          else r.proto = 8'($urandom);
        end else if (cat >= 85) begin
          r.ver_ihl = 8'($urandom);
          r.etype   = 16'($urandom);
          r.proto   = 8'($urandom);
          r.dport   = 16'($urandom);
          r.ulen    = 16'($urandom);
          r.len     = $urandom_range(90, 1);
        end
        send_frame(r);
        nbytes  += r.len;
        nframes++;
        if (p == 1 && nframes == 1) settle();
      end
    end

    settle();
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/ufhf_pkg.sv
rtl/core/ufhf_in_if.sv
rtl/core/ufhf_out_if.sv
rtl/core/udp_flow_header_filter_top.sv
rtl/core/ufhf_checker.sv
tb/udp_flow_header_filter_top_tb.sv
